### rtl/core/dmac_pkg.sv
// Package for the four-channel DMA controller: field widths, codes and shared types.
// No dependencies.
package dmac_pkg;
   localparam int CHANNELS = 4;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   localparam logic [3:0] SEL_CMD       = 4'd0;
   localparam logic [3:0] SEL_MASK_ONE  = 4'd2;
   localparam logic [3:0] SEL_MODE      = 4'd3;
   localparam logic [3:0] SEL_CLR_PTR   = 4'd4;
   localparam logic [3:0] SEL_RESET     = 4'd5;
   localparam logic [3:0] SEL_CLR_MASKS = 4'd6;
   localparam logic [3:0] SEL_ALL_MASKS = 4'd7;
   localparam logic [3:0] SEL_ADDR      = 4'd8;
   localparam logic [3:0] SEL_COUNT     = 4'd9;
   localparam logic [3:0] SEL_PAGE      = 4'd10;
   localparam logic [3:0] SEL_STATUS    = 4'd11;

   localparam logic [1:0] KIND_REG   = 2'd0;
   localparam logic [1:0] KIND_MWR   = 2'd1;
   localparam logic [1:0] KIND_MRD   = 2'd2;
   localparam logic [1:0] KIND_NOREG = 2'd3;

   localparam logic [1:0] XFER_VERIFY = 2'd0;
   localparam logic [1:0] XFER_WRITE  = 2'd1;
   localparam logic [1:0] XFER_READ   = 2'd2;

   localparam logic [5:0] MODE_AUTO = 6'h10 >> 2;
   localparam logic [5:0] MODE_DEC  = 6'h20 >> 2;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  register_select;
      logic [1:0]  channel;
      logic [15:0] write_data;
      logic [3:0]  ready_mask;
      logic [15:0] device_data_0;
      logic [15:0] device_data_1;
      logic [15:0] device_data_2;
      logic [15:0] device_data_3;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  channel_out;
      logic [23:0] address;
      logic [15:0] data;
      logic        last;
   } rsp_type;
endpackage

### rtl/core/dmac_if.sv
// Valid/ready stream interfaces for the request and response channels.
// Depends on dmac_pkg.
interface dmac_req_if;
   import dmac_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface dmac_rsp_if;
   import dmac_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/dmac_rsp_queue.sv
// Response queue: takes up to four words per cycle, delivers one per cycle
// while out_ready is high. Depends on dmac_pkg.
module dmac_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [2:0]           push_count,
   input  dmac_pkg::rsp_type    push_word [4],
   output logic                 space_ok,
   output logic                 out_valid,
   input  logic                 out_ready,
   output dmac_pkg::rsp_type    out_word
);
   import dmac_pkg::*;
   localparam int DEPTH = 8;

   rsp_type    mem_ff [DEPTH];
   logic [2:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       pop;

   assign out_valid = cnt_ff != 4'd0;
   assign out_word  = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   // room for a full tick of four words, not counting the word leaving now
   assign space_ok  = cnt_ff <= 4'd4;

   always_comb begin
      rd_in  = rd_ff + 3'(pop);
      wr_in  = wr_ff + push_count;
      cnt_in = cnt_ff + 4'(push_count) - 4'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < push_count) begin
            mem_ff[wr_ff + 3'(i)] <= push_word[i];
         end
      end
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

### rtl/core/dma_controller_four_channel.sv
// Top level of the four-channel DMA controller: register file, tick engine.
// Depends on dmac_pkg, dmac_if and dmac_rsp_queue.
//
//  port     dir   handshake        carries
//  req      in    valid/ready      command, select, channel, data, ready mask, device data
//  rsp      out   valid/ready      kind, channel, address, data, last
//  csr      in    write enable     word_mode
//
// One item is accepted per cycle while req ready is high; its results are in the
// response queue on the next edge and leave one per cycle while rsp ready is high.
// req ready drops while the queue holds more than four words.
// Synchronous active-high reset; all channels masked, enable set.
module dma_controller_four_channel (
   input  logic clock,
   input  logic reset,
   dmac_req_if.sink   req,
   dmac_rsp_if.source rsp,
   input  logic csr_write_enable,
   input  logic csr_write_data
);
   import dmac_pkg::*;

   logic        word_ff;
   logic [15:0] base_addr_ff [4], base_addr_in [4];
   logic [15:0] cur_addr_ff [4],  cur_addr_in [4];
   logic [15:0] base_cnt_ff [4],  base_cnt_in [4];
   logic [16:0] cur_cnt_ff [4],   cur_cnt_in [4];
   logic [7:0]  page_ff [4],      page_in [4];
   logic [5:0]  mode_ff [4],      mode_in [4];
   logic [3:0]  mask_ff, mask_in;
   logic        hold_ff, hold_in, enable_ff, enable_in, hbn_ff, hbn_in;

   logic        accept, space_ok;
   req_type     r;
   logic [2:0]  n;
   rsp_type     words [4];
   logic [15:0] dd [4];
   logic [15:0] merged, rd_val, rdv;
   logic [7:0]  pmask;

   assign accept    = req.valid && req.ready;
   assign req.ready = space_ok;
   assign r         = req.payload;
   assign dd[0] = r.device_data_0;
   assign dd[1] = r.device_data_1;
   assign dd[2] = r.device_data_2;
   assign dd[3] = r.device_data_3;
   assign pmask = word_ff ? 8'hff : 8'h0f;

   always_comb begin
      base_addr_in = base_addr_ff;
      cur_addr_in  = cur_addr_ff;
      base_cnt_in  = base_cnt_ff;
      cur_cnt_in   = cur_cnt_ff;
      page_in      = page_ff;
      mode_in      = mode_ff;
      mask_in      = mask_ff;
      hold_in      = hold_ff;
      enable_in    = enable_ff;
      hbn_in       = hbn_ff;
      n            = '0;
      merged       = '0;
      rd_val       = '0;
      rdv          = '0;
      for (int i = 0; i < 4; i++) words[i] = '0;
      if (r.command == CMD_WRITE) begin
         // 16-bit merge of the address/count selected
         rdv = (r.register_select == SEL_ADDR) ? base_addr_ff[r.channel]
                                                : base_cnt_ff[r.channel];
         if (word_ff) merged = r.write_data;
         else if (hbn_ff) merged = {r.write_data[7:0], rdv[7:0]};
         else merged = {rdv[15:8], r.write_data[7:0]};
         case (r.register_select)
            SEL_CMD: begin
               hold_in   = r.write_data[1:0] == 2'b11;
               enable_in = r.write_data[2];
            end
            SEL_MASK_ONE: mask_in[r.write_data[1:0]] = r.write_data[2];
            SEL_MODE: mode_in[r.write_data[1:0]] = r.write_data[7:2];
            SEL_CLR_PTR: hbn_in = 1'b0;
            SEL_RESET: begin
               for (int c = 0; c < 4; c++) begin
                  base_addr_in[c] = '0;
                  cur_addr_in[c]  = '0;
                  base_cnt_in[c]  = '0;
                  cur_cnt_in[c]   = '0;
                  page_in[c]      = '0;
               end
               mask_in   = '1;
               hold_in   = 1'b0;
               enable_in = 1'b1;
               hbn_in    = 1'b0;
            end
            SEL_CLR_MASKS: mask_in = '0;
            SEL_ALL_MASKS: mask_in = r.write_data[3:0];
            SEL_ADDR: begin
               base_addr_in[r.channel] = merged;
               hbn_in = ~hbn_ff;
               if (word_ff || hbn_ff) cur_addr_in[r.channel] = merged;
            end
            SEL_COUNT: begin
               base_cnt_in[r.channel] = merged;
               hbn_in = ~hbn_ff;
               if (word_ff) cur_cnt_in[r.channel] = {merged, 1'b0};
               else if (hbn_ff) cur_cnt_in[r.channel] = {1'b0, merged};
            end
            SEL_PAGE: page_in[r.channel] = r.write_data[7:0] & pmask;
            default: ;
         endcase
      end else if (r.command == CMD_READ) begin
         n = 3'd1;
         words[0].kind = KIND_REG;
         words[0].channel_out = r.channel;
         rdv = (r.register_select == SEL_ADDR) ? base_addr_ff[r.channel]
                                                : base_cnt_ff[r.channel];
         case (r.register_select)
            SEL_STATUS:
               for (int c = 0; c < 4; c++) rd_val[c] = cur_cnt_ff[c] == '1;
            SEL_ADDR, SEL_COUNT: begin
               hbn_in = ~hbn_ff;
               if (word_ff) rd_val = rdv;
               else if (hbn_ff) rd_val = {8'h00, rdv[15:8]};
               else rd_val = {8'h00, rdv[7:0]};
            end
            SEL_PAGE: rd_val = {8'h00, page_ff[r.channel] & pmask};
            default: words[0].kind = KIND_NOREG;
         endcase
         words[0].data = rd_val;
      end else if (r.command == CMD_TICK && enable_ff) begin
         for (int c = 0; c < CHANNELS; c++) begin
            if (!mask_ff[c]) begin
               logic step;
               step = 1'b0;
               case (mode_ff[c][1:0])
                  XFER_VERIFY: step = r.ready_mask[c];
                  XFER_WRITE: begin
                     step = r.ready_mask[c];
                     if (step) begin
                        words[n[1:0]].kind = KIND_MWR;
                        words[n[1:0]].channel_out = 2'(c);
                        words[n[1:0]].address = {page_ff[c], cur_addr_ff[c]};
                        words[n[1:0]].data = word_ff ? dd[c] : {8'h00, dd[c][7:0]};
                        n = n + 3'd1;
                     end
                  end
                  XFER_READ: begin
                     step = r.ready_mask[c];
                     words[n[1:0]].kind = KIND_MRD;
                     words[n[1:0]].channel_out = 2'(c);
                     words[n[1:0]].address = {page_ff[c], cur_addr_ff[c]};
                     n = n + 3'd1;
                  end
                  default: ;
               endcase
               if (step) begin
                  if (!(c == 0 && hold_ff)) begin
                     cur_addr_in[c] = (mode_ff[c] & MODE_DEC) != '0
                                      ? cur_addr_ff[c] - 16'd1 : cur_addr_ff[c] + 16'd1;
                  end
                  cur_cnt_in[c] = cur_cnt_ff[c] - 17'd1;
                  if (cur_cnt_ff[c] == '0) begin
                     mask_in[c] = 1'b1;
                     if ((mode_ff[c] & MODE_AUTO) != '0) begin
                        cur_addr_in[c] = base_addr_ff[c];
                        cur_cnt_in[c] = word_ff ? {base_cnt_ff[c], 1'b0}
                                                : {1'b0, base_cnt_ff[c]};
                     end
                  end
               end
            end
         end
      end
      if (n != '0) words[2'(n - 3'd1)].last = 1'b1;
   end

   dmac_rsp_queue u_queue (
      .clock(clock), .reset(reset),
      .push_count(accept ? n : 3'd0), .push_word(words), .space_ok(space_ok),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_word(rsp.payload)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff   <= 1'b0;
         mask_ff   <= '1;
         hold_ff   <= 1'b0;
         enable_ff <= 1'b1;
         hbn_ff    <= 1'b0;
         for (int c = 0; c < 4; c++) begin
            base_addr_ff[c] <= '0;
            cur_addr_ff[c]  <= '0;
            base_cnt_ff[c]  <= '0;
            cur_cnt_ff[c]   <= '0;
            page_ff[c]      <= '0;
            mode_ff[c]      <= '0;
         end
      end else begin
         if (csr_write_enable) word_ff <= csr_write_data;
         if (accept) begin
            base_addr_ff <= base_addr_in;
            cur_addr_ff  <= cur_addr_in;
            base_cnt_ff  <= base_cnt_in;
            cur_cnt_ff   <= cur_cnt_in;
            page_ff      <= page_in;
            mode_ff      <= mode_in;
            mask_ff      <= mask_in;
            hold_ff      <= hold_in;
            enable_ff    <= enable_in;
            hbn_ff       <= hbn_in;
         end
      end
   end

   a_reset_masks: assert property (@(posedge clock) reset |=> mask_ff == 4'hf && enable_ff)
      else $error("reset did not mask all channels");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !space_ok |-> !req.ready)
      else $error("request taken with queue full");
   a_read_one: assert property (@(posedge clock) disable iff (reset)
      accept && r.command == CMD_READ |-> n == 3'd1)
      else $error("register read must give one word");
endmodule
